### src/hds_pkg.sv
// hds_pkg: shared types and constants for the heat diffusion stencil sweep.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package hds_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAMMA     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SWEEP = 3'd4;

   localparam int LAP_W   = 36;
   localparam int PROD_W  = 53;
   localparam int DELTA_W = 37;
   localparam int SUM_W   = 48;

   localparam logic KIND_CELL    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL,
      ST_SQR,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic mul;
      logic sqr;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic can_commit;
   } status_type;

endpackage

`default_nettype wire

### src/hds_ctrl.sv
// hds_ctrl: sequencing state machine for one request at a time.
// Depends on hds_pkg for the state, command and status types.
`default_nettype none

module hds_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  hds_pkg::status_type status,
   output hds_pkg::cmd_type    cmd
);

   hds_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hds_pkg::ST_IDLE: begin
            if (req_valid) state_in = hds_pkg::ST_LOAD;
         end
         hds_pkg::ST_LOAD:   state_in = hds_pkg::ST_MUL;
         hds_pkg::ST_MUL:    state_in = hds_pkg::ST_SQR;
         hds_pkg::ST_SQR:    state_in = hds_pkg::ST_COMMIT;
         hds_pkg::ST_COMMIT: begin
            if (status.can_commit) state_in = hds_pkg::ST_IDLE;
         end
         default: state_in = hds_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         hds_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         hds_pkg::ST_LOAD:   cmd.load = 1'b1;
         hds_pkg::ST_MUL:    cmd.mul  = 1'b1;
         hds_pkg::ST_SQR:    cmd.sqr  = 1'b1;
         hds_pkg::ST_COMMIT: cmd.commit = status.can_commit;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### src/hds_datapath.sv
// hds_datapath: config registers, line buffers, window, stencil arithmetic,
// accumulator and output register. Depends on hds_pkg; driven by hds_ctrl.
`default_nettype none

module hds_datapath #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  hds_pkg::cmd_type                        cmd,
   output hds_pkg::status_type                     status,
   input  wire signed [31:0]                       req_temperature,
   input  wire                                     csr_wr,
   input  wire [hds_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  wire [hds_pkg::CSR_DATA_BITS-1:0]        csr_data,
   output logic                                    rsp_valid,
   input  wire                                     rsp_stall,
   output logic                                    rsp_kind,
   output logic signed [31:0]                      rsp_new_temperature,
   output logic [47:0]                             rsp_delta_square_sum,
   output logic                                    rsp_converged,
   output logic [31:0]                             rsp_sweep_count
);

   localparam int DEPTH    = MAX_WIDTH + 2;
   localparam int AW       = $clog2(DEPTH);
   localparam int SAT_BITS = (VALUE_BITS > 32) ? 32 : VALUE_BITS;
   localparam int NV_W     = hds_pkg::DELTA_W + 1;
   localparam logic signed [NV_W-1:0] SAT_HI = NV_W'((64'sd1 <<< (SAT_BITS - 1)) - 1);
   localparam logic signed [NV_W-1:0] SAT_LO = -SAT_HI - NV_W'(1);

   // configuration
   logic [15:0] gamma_ff;
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [47:0] thr_ff;
   logic [31:0] max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff  <= '0;
         width_ff  <= 11'd1;
         height_ff <= 16'd1;
         thr_ff    <= '0;
         max_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_index)
            hds_pkg::CSR_GAMMA:     gamma_ff  <= csr_data[15:0];
            hds_pkg::CSR_WIDTH:     width_ff  <= csr_data[10:0];
            hds_pkg::CSR_HEIGHT:    height_ff <= csr_data[15:0];
            hds_pkg::CSR_THRESHOLD: thr_ff    <= csr_data[47:0];
            hds_pkg::CSR_MAX_SWEEP: max_ff    <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   logic [10:0] w_eff;
   logic [15:0] h_eff;

   always_comb begin
      w_eff = width_ff;
      if (width_ff == 11'd0) w_eff = 11'd1;
      else if (32'(width_ff) > MAX_WIDTH) w_eff = 11'(MAX_WIDTH);
      h_eff = (height_ff == 16'd0) ? 16'd1 : height_ff;
   end

   // raster position
   logic [10:0] col_ff;
   logic [16:0] row_ff;
   logic        wrap_col, end_sweep, is_cell;

   assign wrap_col  = {1'b0, col_ff} >= ({1'b0, w_eff} + 12'd1);
   assign end_sweep = wrap_col && (row_ff >= ({1'b0, h_eff} + 17'd1));
   assign is_cell   = (row_ff >= 17'd2) && (row_ff <= ({1'b0, h_eff} + 17'd1)) &&
                      (col_ff >= 11'd1) && (col_ff <= w_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.accept) begin
         if (end_sweep) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (wrap_col) begin
            col_ff <= '0;
            row_ff <= row_ff + 17'd1;
         end else begin
            col_ff <= col_ff + 11'd1;
         end
      end
   end

   // captured request
   logic [10:0]        cur_col_ff;
   logic signed [31:0] raw_ff;
   logic               cell_ff, summ_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_col_ff <= col_ff;
         raw_ff     <= req_temperature;
         cell_ff    <= is_cell;
         summ_ff    <= end_sweep;
      end
   end

   // line buffers, two read addresses each: next column and column zero
   logic [31:0] upper_mem [DEPTH];
   logic [31:0] middle_mem [DEPTH];
   logic [31:0] nxt_col;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_ok;
   logic [31:0] up_a_ff, up_0_ff, mid_a_ff, mid_0_ff;

   assign nxt_col = 32'(col_ff) + 32'd1;
   assign rd_addr = (nxt_col < DEPTH) ? AW'(nxt_col) : '0;
   assign wr_ok   = 32'(cur_col_ff) < DEPTH;
   assign wr_addr = AW'(cur_col_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         up_a_ff  <= upper_mem[rd_addr];
         mid_a_ff <= middle_mem[rd_addr];
         up_0_ff  <= upper_mem[0];
         mid_0_ff <= middle_mem[0];
      end
   end

   // window: north, west, center
   logic signed [31:0] win_n_ff, win_w_ff, win_c_ff;
   logic signed [31:0] n_v, c_v;
   logic signed [hds_pkg::LAP_W-1:0] lap;

   assign n_v = (cur_col_ff == 11'd0) ? $signed(up_0_ff) : win_n_ff;
   assign c_v = (cur_col_ff == 11'd0) ? $signed(mid_0_ff) : win_c_ff;
   assign lap = hds_pkg::LAP_W'(n_v) + hds_pkg::LAP_W'(win_w_ff) +
                hds_pkg::LAP_W'($signed(mid_a_ff)) + hds_pkg::LAP_W'(raw_ff) -
                (hds_pkg::LAP_W'(c_v) <<< 2);

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         upper_mem[wr_addr]  <= c_v;
         middle_mem[wr_addr] <= raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_n_ff <= '0;
         win_w_ff <= '0;
         win_c_ff <= '0;
      end else if (cmd.load) begin
         win_n_ff <= $signed(up_a_ff);
         win_w_ff <= c_v;
         win_c_ff <= $signed(mid_a_ff);
      end
   end

   logic signed [hds_pkg::LAP_W-1:0]   lap_ff;
   logic signed [31:0]                 c_ff;
   logic signed [hds_pkg::PROD_W-1:0]  prod, prod_rnd;
   logic signed [hds_pkg::DELTA_W-1:0] delta_ff;

   // truncate toward zero: bias negative products before the shift
   assign prod     = hds_pkg::PROD_W'($signed({1'b0, gamma_ff})) *
                     hds_pkg::PROD_W'(lap_ff);
   assign prod_rnd = prod + (prod[hds_pkg::PROD_W-1] ?
                     hds_pkg::PROD_W'(65535) : hds_pkg::PROD_W'(0));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lap_ff <= lap;
         c_ff   <= c_v;
      end
      if (cmd.mul) begin
         delta_ff <= hds_pkg::DELTA_W'(prod_rnd >>> 16);
      end
   end

   logic [hds_pkg::DELTA_W-1:0] mag;
   logic [63:0]                 sq_full;
   logic signed [NV_W-1:0]      nv_sum;
   logic [hds_pkg::SUM_W-1:0]   sq_ff;
   logic signed [31:0]          nv_ff;

   assign mag     = delta_ff[hds_pkg::DELTA_W-1] ? 
                    hds_pkg::DELTA_W'(-delta_ff) : hds_pkg::DELTA_W'(delta_ff);
   assign sq_full = 64'(mag[31:0]) * 64'(mag[31:0]);
   assign nv_sum  = NV_W'(c_ff) + NV_W'(delta_ff);

   always_ff @(posedge clock) begin
      if (cmd.sqr) begin
         sq_ff <= (|mag[hds_pkg::DELTA_W-1:32]) ? '1 : sq_full[63:16];
         if (nv_sum > SAT_HI)      nv_ff <= 32'(SAT_HI);
         else if (nv_sum < SAT_LO) nv_ff <= 32'(SAT_LO);
         else                      nv_ff <= 32'(nv_sum);
      end
   end

   // accumulator, sweep counter, output register
   logic [hds_pkg::SUM_W-1:0] acc_ff;
   logic [31:0]               sweep_ff;
   logic [hds_pkg::SUM_W:0]   acc_add;
   logic                      emit, out_free;

   assign acc_add  = {1'b0, acc_ff} + {1'b0, sq_ff};
   assign emit     = cell_ff || summ_ff;
   assign out_free = !rsp_valid || !rsp_stall;
   assign status.can_commit = !emit || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         sweep_ff <= '0;
      end else if (cmd.commit) begin
         if (summ_ff) begin
            acc_ff   <= '0;
            sweep_ff <= sweep_ff + 32'd1;
         end else if (cell_ff) begin
            acc_ff <= acc_add[hds_pkg::SUM_W] ? '1 : acc_add[hds_pkg::SUM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.commit && emit) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && emit) begin
         if (summ_ff) begin
            rsp_kind             <= hds_pkg::KIND_SUMMARY;
            rsp_new_temperature  <= '0;
            rsp_delta_square_sum <= acc_ff;
            rsp_converged        <= (acc_ff < thr_ff) || (sweep_ff >= max_ff);
            rsp_sweep_count      <= sweep_ff;
         end else begin
            rsp_kind             <= hds_pkg::KIND_CELL;
            rsp_new_temperature  <= nv_ff;
            rsp_delta_square_sum <= '0;
            rsp_converged        <= 1'b0;
            rsp_sweep_count      <= '0;
         end
      end
   end

endmodule

`default_nettype wire

### src/heat_diffusion_stencil_sweep.sv
// Five-point explicit heat sweep over a halo-padded grid streamed in raster order.
// After acceptance a request's result passes through the load, multiply, square and
// commit steps into the output register; the next request is taken only once the
// controller has walked the current one through its states and returned to idle, so
// requests never overlap. A stalled result holds the commit step until the output register frees.
// Synchronous active-high reset clears control, positions, window and accumulator;
// line buffer contents are undefined until written.
`default_nettype none

module heat_diffusion_stencil_sweep #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_valid,
   output logic                                req_stall,
   input  wire signed [31:0]                   req_temperature,
   output logic                                rsp_valid,
   input  wire                                 rsp_stall,
   output logic                                rsp_kind,
   output logic signed [31:0]                  rsp_new_temperature,
   output logic [47:0]                         rsp_delta_square_sum,
   output logic                                rsp_converged,
   output logic [31:0]                         rsp_sweep_count,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [hds_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire [hds_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   hds_pkg::cmd_type    cmd;
   hds_pkg::status_type status;

   assign csr_ready = 1'b1;

   hds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hds_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_temperature      (req_temperature),
      .csr_wr               (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_kind             (rsp_kind),
      .rsp_new_temperature  (rsp_new_temperature),
      .rsp_delta_square_sum (rsp_delta_square_sum),
      .rsp_converged        (rsp_converged),
      .rsp_sweep_count      (rsp_sweep_count)
   );

endmodule

`default_nettype wire

### src/hds_checker.sv
// hds_checker: port-level assertions for the stencil sweep top level,
// bound to heat_diffusion_stencil_sweep. Depends on hds_pkg.
`default_nettype none

module hds_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire        rsp_kind,
   input wire [31:0] rsp_new_temperature,
   input wire [47:0] rsp_delta_square_sum,
   input wire        rsp_converged,
   input wire [31:0] rsp_sweep_count
);

   // one request in flight: the block holds off right after taking one
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another in flight");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_summary_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == hds_pkg::KIND_SUMMARY) |-> rsp_new_temperature == 32'd0)
      else $error("summary carries a cell value");

   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == hds_pkg::KIND_CELL) |->
      (rsp_delta_square_sum == 48'd0 && !rsp_converged && rsp_sweep_count == 32'd0))
      else $error("cell result carries summary fields");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_new_temperature) &&
      $stable(rsp_kind) && $stable(rsp_delta_square_sum)))
      else $error("stalled result changed");

endmodule

bind heat_diffusion_stencil_sweep hds_checker u_hds_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_kind             (rsp_kind),
   .rsp_new_temperature  (rsp_new_temperature),
   .rsp_delta_square_sum (rsp_delta_square_sum),
   .rsp_converged        (rsp_converged),
   .rsp_sweep_count      (rsp_sweep_count)
);

`default_nettype wire

### test/heat_diffusion_stencil_sweep_tb.sv
// Self-checking testbench for heat_diffusion_stencil_sweep: padded grids are streamed in,
// and every cell update and sweep summary is checked against an in-bench stencil predictor.
// Depends on hds_pkg and heat_diffusion_stencil_sweep (src/).
`default_nettype none

module heat_diffusion_stencil_sweep_tb;

   localparam int BUF_DEPTH = 1026;
   localparam int WD_LIMIT = 5000;
   localparam int SETTLE = 20;
   localparam int ITEMS = 1300;
   localparam logic [hds_pkg::CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd5;
   localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      logic        kind;
      logic [31:0] temp;
      logic [47:0] sum;
      logic        conv;
      logic [31:0] count;
   } sweep_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [31:0] req_temperature = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_kind;
   logic [31:0] rsp_new_temperature;
   logic [47:0] rsp_delta_square_sum;
   logic rsp_converged;
   logic [31:0] rsp_sweep_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic [hds_pkg::CSR_INDEX_BITS-1:0] csr_index = 0;
   logic [hds_pkg::CSR_DATA_BITS-1:0] csr_data = 0;

   heat_diffusion_stencil_sweep dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [15:0] cfg_gamma = 0;
   logic [10:0] cfg_width = 1;
   logic [15:0] cfg_height = 1;
   logic [47:0] cfg_threshold = 0;
   logic [31:0] cfg_max_sweeps = 0;
   logic [31:0] line_upper [BUF_DEPTH];
   logic [31:0] line_middle [BUF_DEPTH];
   logic [31:0] win [9];
   logic [10:0] col_pos = 0;
   logic [16:0] row_pos = 0;
   logic [47:0] delta_sq_acc = 0;
   logic [31:0] sweep_num = 0;

   logic [31:0] cell_queue [$];
   sweep_result_type expected_q [$];
   int errors = 0;
   int src_idle, snk_idle;
   int accepted = 0;
   int pushed = 0;
   int quiet_cycles = 0;

   initial begin
      foreach (line_upper[i]) begin
         line_upper[i] = 0;
         line_middle[i] = 0;
      end
      foreach (win[i]) win[i] = 0;
   end

   // idle mix by phase: sender mostly busy first, then the receiver, then neither idles
   always_comb begin
      if (accepted < ITEMS / 3) begin
         src_idle = 18;
         snk_idle = 81;
      end else if (accepted < 2 * ITEMS / 3) begin
         src_idle = 81;
         snk_idle = 18;
      end else begin
         src_idle = 0;
         snk_idle = 0;
      end
   end

   function automatic void predict_cell(logic [31:0] raw);
      int unsigned w, h, pc, pr;
      longint c, lap, delta, nv;
      longint unsigned mag, sq;
      sweep_result_type r;
      w = 32'(cfg_width);
      h = 32'(cfg_height);
      pc = 32'(col_pos);
      pr = 32'(row_pos);
      if (w < 1) w = 1;
      if (w > 1024) w = 1024;
      if (h < 1) h = 1;
      if (pc == 0) begin
         win[1] = line_upper[0];
         win[4] = line_middle[0];
      end
      win[2] = (pc + 1 < BUF_DEPTH) ? line_upper[pc + 1] : 32'd0;
      win[5] = (pc + 1 < BUF_DEPTH) ? line_middle[pc + 1] : 32'd0;
      win[7] = raw;
      if (pr >= 2 && pr <= h + 1 && pc >= 1 && pc <= w) begin
         c = longint'($signed(win[4]));
         lap = longint'($signed(win[1])) + longint'($signed(win[3]))
             + longint'($signed(win[5])) + longint'($signed(raw)) - 4 * c;
         delta = (longint'(cfg_gamma) * lap) / 65536;
         mag = (delta < 0) ? 64'(-delta) : 64'(delta);
         sq = (mag >= 64'h1_0000_0000) ? 64'(SUM_MAX) : (mag * mag) >> 16;
         if (sq > SUM_MAX) sq = 64'(SUM_MAX);
         sq = sq + 64'(delta_sq_acc);
         delta_sq_acc = (sq > SUM_MAX) ? SUM_MAX : sq[47:0];
         nv = c + delta;
         if (nv > 64'sd2147483647) nv = 64'sd2147483647;
         if (nv < -64'sd2147483648) nv = -64'sd2147483648;
         r.kind = hds_pkg::KIND_CELL;
         r.temp = nv[31:0];
         r.sum = '0;
         r.conv = 1'b0;
         r.count = '0;
         expected_q.push_back(r);
      end
      if (pc < BUF_DEPTH) begin
         line_upper[pc] = line_middle[pc];
         line_middle[pc] = raw;
      end
      for (int k = 0; k < 3; k++) begin
         win[k * 3] = win[k * 3 + 1];
         win[k * 3 + 1] = win[k * 3 + 2];
      end
      if (pr >= h + 1 && pc >= w + 1) begin
         r.kind = hds_pkg::KIND_SUMMARY;
         r.temp = '0;
         r.sum = delta_sq_acc;
         r.conv = (delta_sq_acc < cfg_threshold) || (sweep_num >= cfg_max_sweeps);
         r.count = sweep_num;
         expected_q.push_back(r);
         sweep_num = sweep_num + 32'd1;
         delta_sq_acc = '0;
         col_pos = '0;
         row_pos = '0;
      end else if (pc >= w + 1) begin
         col_pos = '0;
         row_pos = 17'(pr + 1);
      end else begin
         col_pos = 11'(pc + 1);
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_cell(req_temperature);
            accepted <= accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (cell_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
               req_valid <= 1'b1;
               req_temperature <= cell_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      sweep_result_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < snk_idle);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result kind=%0d", rsp_kind);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (rsp_kind !== e.kind) begin
                  $error("kind: expected %0d actual %0d", e.kind, rsp_kind);
                  errors++;
               end
               if (rsp_new_temperature !== e.temp) begin
                  $error("new_temperature: expected %h actual %h", e.temp,
                         rsp_new_temperature);
                  errors++;
               end
               if (rsp_delta_square_sum !== e.sum) begin
                  $error("delta_square_sum: expected %h actual %h", e.sum,
                         rsp_delta_square_sum);
                  errors++;
               end
               if (rsp_converged !== e.conv) begin
                  $error("converged: expected %0d actual %0d", e.conv, rsp_converged);
                  errors++;
               end
               if (rsp_sweep_count !== e.count) begin
                  $error("sweep_count: expected %0d actual %0d", e.count,
                         rsp_sweep_count);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (quiet_cycles >= WD_LIMIT) begin
            $display("FAIL heat_diffusion_stencil_sweep");
            $finish;
         end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
                      || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic write_csr(logic [hds_pkg::CSR_INDEX_BITS-1:0] idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         hds_pkg::CSR_GAMMA:     cfg_gamma = val[15:0];
         hds_pkg::CSR_WIDTH:     cfg_width = val[10:0];
         hds_pkg::CSR_HEIGHT:    cfg_height = val[15:0];
         hds_pkg::CSR_THRESHOLD: cfg_threshold = val;
         hds_pkg::CSR_MAX_SWEEP: cfg_max_sweeps = val[31:0];
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [15:0] g, logic [10:0] w, logic [15:0] h,
                           logic [47:0] thr, logic [31:0] ms);
      write_csr(hds_pkg::CSR_GAMMA, 48'(g));
      write_csr(hds_pkg::CSR_WIDTH, 48'(w));
      write_csr(hds_pkg::CSR_HEIGHT, 48'(h));
      write_csr(hds_pkg::CSR_THRESHOLD, thr);
      write_csr(hds_pkg::CSR_MAX_SWEEP, 48'(ms));
   endtask

   task automatic push_cell(logic [31:0] v);
      cell_queue.push_back(v);
      pushed++;
   endtask

   // block may stay busy after its last result, even when nothing more is due
   task automatic drain();
      do @(negedge clock);
      while (cell_queue.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_cell(int style);
      case (style)
         0: return $urandom;
         1: return $urandom_range(4095) << $urandom_range(20);
         2: return -($urandom_range(4095) << $urandom_range(20));
         default: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   initial begin
      int w, h, n, style;
      logic [15:0] g;
      logic [47:0] thr;
      logic [31:0] ms;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: 1x1 grid, gamma zero; extreme values around the center
      write_csr(CSR_UNUSED, SUM_MAX);
      for (int i = 0; i < 9; i++) push_cell(rand_cell(3));
      drain();
      // full gamma, 2x2, extreme neighbors saturate the update and the sum
      set_grid(16'hFFFF, 11'd2, 16'd2, SUM_MAX, 32'hFFFF_FFFF);
      for (int i = 0; i < 16; i++)
         push_cell((i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      drain();
      // one full 8-wide sweep fills every line entry the random grids use
      set_grid(16'h4000, 11'd8, 16'd1, 48'd0, 32'd0);
      for (int i = 0; i < 30; i++) push_cell(rand_cell(i % 3));
      drain();
      // oversize width wraps at full width; zero height counts as one row.
      // The width then drops mid-row, so the next request wraps at once.
      set_grid(16'h8000, 11'h7FF, 16'd0, 48'd0, 32'd0);
      for (int i = 0; i < 1030; i++) push_cell(rand_cell(i % 3));
      drain();
      write_csr(hds_pkg::CSR_WIDTH, 48'd2);
      for (int i = 0; i < 5; i++) push_cell(rand_cell(1));
      drain();
      // zero width counts as one column
      set_grid(16'h1234, 11'd0, 16'd3, 48'h1_0000, 32'd2);
      for (int i = 0; i < 15; i++) push_cell(rand_cell(1));
      drain();

      // random grids up to 8 wide; their line entries are written, so sizes may
      // change mid-sweep
      while (pushed < ITEMS) begin
         case ($urandom_range(3))
            0: g = 0;
            1: g = 16'hFFFF;
            default: g = 16'($urandom);
         endcase
         w = $urandom_range(8);
         h = ($urandom_range(5) == 0) ? 0 : $urandom_range(6);
         case ($urandom_range(2))
            0: thr = rand48();
            1: thr = rand48() >> $urandom_range(47);
            default: thr = $urandom_range(1) ? SUM_MAX : 48'h0;
         endcase
         case ($urandom_range(2))
            0: ms = $urandom;
            1: ms = $urandom_range(4);
            default: ms = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         endcase
         set_grid(g, 11'(w), 16'(h), thr, ms);
         n = ((h < 1 ? 1 : h) + 2) * ((w < 1 ? 1 : w) + 2) * $urandom_range(1, 2);
         if ($urandom_range(3) == 0) n = n + $urandom_range(1, 20) - 10;
         if (n < 1) n = 1;
         style = $urandom_range(3);
         for (int i = 0; i < n; i++)
            push_cell(rand_cell(style == 3 && $urandom_range(3) != 0 ? 0 : style));
         drain();
      end

      if (errors == 0) begin
         $display("PASS heat_diffusion_stencil_sweep");
      end else begin
         $display("FAIL heat_diffusion_stencil_sweep");
      end
      $finish;
   end

endmodule

`default_nettype wire
